// File: rtl/fpc_pkg.sv
// Shared types, constants and the CRC16 byte update for the framed packet checker.
package fpc_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int CH_W         = 1;

  localparam logic [7:0]  SYNC_BYTE   = 8'h7e;
  localparam logic [15:0] CRC_INIT    = 16'hffff;
  localparam logic [7:0]  MIN_LENGTH  = 8'd3;
  localparam logic [3:0]  SEQ_MARKER  = 4'h1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_SYNC = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic [7:0]      data_byte;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic [7:0]      frame_length;
    logic [3:0]      seq_number;
    logic            short_error;
    logic            sync_error;
    logic            crc_error;
    logic            marker_error;
    logic            seq_error;
  } result_t;

  // Handshake status passed from the result register back to the pipeline.
  typedef struct packed {
    logic out_free;
    logic advance;
  } flow_t;

  // One byte of the reflected CRC16-CCITT update.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] d;
    d = b ^ crc[7:0];
    d = d ^ {d[3:0], 4'h0};
    return {d, crc[15:8]} ^ {12'h000, d[7:4]} ^ {5'b00000, d, 3'b000};
  endfunction

endpackage

// File: rtl/fpc_in_stage.sv
// Input register: holds one accepted word until the frame engine takes it.
module fpc_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fpc_pkg::item_t   in_item,
  input  fpc_pkg::flow_t   flow,
  output logic             s1_valid,
  output fpc_pkg::item_t   s1_item
);

  logic           valid_r, valid_nxt;
  fpc_pkg::item_t item_r;
  logic           accept;

  assign in_ready = !valid_r || flow.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (flow.advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// File: rtl/fpc_frame_engine.sv
// Per-channel frame state and the frame, CRC and sequence checks.
module fpc_frame_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  fpc_pkg::item_t    s1_item,
  input  fpc_pkg::flow_t    flow,
  output logic              res_valid,
  output fpc_pkg::result_t  res
);

  localparam int N = fpc_pkg::NUM_CHANNELS;

  fpc_pkg::phase_t phase_r   [N];
  logic [7:0]      remain_r  [N];
  logic [7:0]      count_r   [N];
  logic [7:0]      length_r  [N];
  logic [7:0]      seqb_r    [N];
  logic [15:0]     crc_r     [N];
  logic [15:0]     delay_r   [N];
  logic [3:0]      exp_seq_r [N];
  logic            exp_vld_r [N];

  fpc_pkg::phase_t phase_nxt;
  logic [7:0]      remain_nxt, count_nxt, length_nxt, seqb_nxt;
  logic [15:0]     crc_nxt, delay_nxt;
  logic [3:0]      exp_seq_nxt;
  logic            exp_vld_nxt;

  logic [fpc_pkg::CH_W-1:0] ch;
  logic [7:0]               data;
  logic                     ch_ok;
  logic                     wr_en;
  logic [3:0]               nib;
  logic [3:0]               exp_eff;
  logic                     hit;

  assign ch    = s1_item.channel;
  assign data  = s1_item.data_byte;
  assign ch_ok = int'(ch) < N;
  assign wr_en = flow.advance && ch_ok;
  assign nib   = seqb_r[ch][3:0];
  // The first frame on a channel sets the expected sequence number.
  assign exp_eff = exp_vld_r[ch] ? exp_seq_r[ch] : nib;

  always_comb begin
    phase_nxt   = phase_r[ch];
    remain_nxt  = remain_r[ch];
    count_nxt   = count_r[ch];
    length_nxt  = length_r[ch];
    seqb_nxt    = seqb_r[ch];
    crc_nxt     = crc_r[ch];
    delay_nxt   = delay_r[ch];
    exp_seq_nxt = exp_seq_r[ch];
    exp_vld_nxt = exp_vld_r[ch];
    hit         = 1'b0;
    res         = '0;
    res.channel = ch;

    unique case (phase_r[ch])
      fpc_pkg::PH_BODY: begin
        // The CRC trails the input by two words so the received CRC is never folded in.
        if (count_r[ch] >= 8'd2) begin
          crc_nxt = fpc_pkg::crc16_step(crc_r[ch], delay_r[ch][15:8]);
        end
        delay_nxt = {delay_r[ch][7:0], data};
        if (count_r[ch] == 8'd1) begin
          seqb_nxt = data;
        end
        count_nxt  = count_r[ch] + 8'd1;
        remain_nxt = remain_r[ch] - 8'd1;
        if (remain_nxt == 8'd0) begin
          phase_nxt = fpc_pkg::PH_SYNC;
        end
      end
      fpc_pkg::PH_SYNC: begin
        hit              = 1'b1;
        res.frame_length = length_r[ch];
        res.seq_number   = nib;
        res.sync_error   = data != fpc_pkg::SYNC_BYTE;
        res.crc_error    = crc_r[ch] != delay_r[ch];
        res.marker_error = seqb_r[ch][7:4] != fpc_pkg::SEQ_MARKER;
        res.seq_error    = nib != exp_eff;
        exp_seq_nxt      = exp_eff + 4'd1;
        exp_vld_nxt      = 1'b1;
        phase_nxt        = fpc_pkg::PH_IDLE;
      end
      default: begin
        phase_nxt = fpc_pkg::PH_IDLE;
        if (data == fpc_pkg::SYNC_BYTE) begin
          hit = 1'b0;
        end else if (data < fpc_pkg::MIN_LENGTH) begin
          hit              = 1'b1;
          res.frame_length = data;
          res.short_error  = 1'b1;
        end else begin
          length_nxt = data;
          remain_nxt = data - 8'd2;
          count_nxt  = 8'd1;
          delay_nxt  = {8'h00, data};
          crc_nxt    = fpc_pkg::CRC_INIT;
          seqb_nxt   = 8'h00;
          phase_nxt  = fpc_pkg::PH_BODY;
        end
      end
    endcase
  end

  assign res_valid = s1_valid && ch_ok && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        phase_r[i]   <= fpc_pkg::PH_IDLE;
        exp_vld_r[i] <= 1'b0;
      end
    end else if (wr_en) begin
      phase_r[ch]   <= phase_nxt;
      exp_vld_r[ch] <= exp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      remain_r[ch]  <= remain_nxt;
      count_r[ch]   <= count_nxt;
      length_r[ch]  <= length_nxt;
      seqb_r[ch]    <= seqb_nxt;
      crc_r[ch]     <= crc_nxt;
      delay_r[ch]   <= delay_nxt;
      exp_seq_r[ch] <= exp_seq_nxt;
    end
  end

endmodule

// File: rtl/fpc_out_stage.sv
// Result register and the advance control for the stage in front of it.
module fpc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  logic              res_valid,
  input  fpc_pkg::result_t  res,
  output fpc_pkg::flow_t    flow,
  output logic              out_valid,
  input  logic              out_ready,
  output fpc_pkg::result_t  out_res
);

  logic             valid_r, valid_nxt;
  fpc_pkg::result_t res_r;
  logic             load;

  assign flow.out_free = !valid_r || out_ready;
  assign flow.advance  = s1_valid && flow.out_free;
  assign load          = flow.advance && res_valid;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: rtl/crc16_framed_packet_checker.sv
// Top level of the two-channel CRC16 framed packet checker.
//
//   Channel | Handshake              | Payload
//   in      | in_valid / in_ready    | in_channel, in_data_byte
//   out     | out_valid / out_ready  | out_channel, out_frame_length, out_seq_number, flags
//
// One word is accepted every cycle unless a stalled result register holds the flow; a word
// lands in the input register when it is accepted, and the frame engine then loads its result
// into the output register when the word advances.
// The rate is set by the CRC byte update and per-channel state write, both done as a word advances.
// While the result register is full and not taken, the input register holds and in_ready
// drops once it is occupied. Synchronous reset returns both channels to idle with no
// sequence number seen.
module crc16_framed_packet_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_channel,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_channel,
  output logic [7:0] out_frame_length,
  output logic [3:0] out_seq_number,
  output logic       out_short_error,
  output logic       out_sync_error,
  output logic       out_crc_error,
  output logic       out_marker_error,
  output logic       out_seq_error
);

  fpc_pkg::item_t   in_item, s1_item;
  fpc_pkg::flow_t   flow;
  fpc_pkg::result_t res, out_res;
  logic             s1_valid, res_valid;

  assign in_item.channel   = in_channel;
  assign in_item.data_byte = in_data_byte;

  fpc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .flow     (flow),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  fpc_frame_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .flow      (flow),
    .res_valid (res_valid),
    .res       (res)
  );

  fpc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res_valid (res_valid),
    .res       (res),
    .flow      (flow),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_channel      = out_res.channel;
  assign out_frame_length = out_res.frame_length;
  assign out_seq_number   = out_res.seq_number;
  assign out_short_error  = out_res.short_error;
  assign out_sync_error   = out_res.sync_error;
  assign out_crc_error    = out_res.crc_error;
  assign out_marker_error = out_res.marker_error;
  assign out_seq_error    = out_res.seq_error;

endmodule

// File: rtl/fpc_checker.sv
// Port-level assertions for the framed packet checker and their bind.
module fpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_channel,
  input logic [7:0] out_frame_length,
  input logic [3:0] out_seq_number,
  input logic       out_short_error,
  input logic       out_sync_error,
  input logic       out_crc_error,
  input logic       out_marker_error,
  input logic       out_seq_error
);

  // A stalled result word stays valid and holds its channel, length and sequence number.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_length)
      && $stable(out_channel) && $stable(out_seq_number))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A dropped short frame carries no other check result.
  a_short_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_short_error |-> !out_sync_error && !out_crc_error
      && !out_marker_error && !out_seq_error && out_seq_number == 4'd0)
    else $error("short frame reported with other flags");

  a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_short_error |-> out_frame_length < 8'd3)
    else $error("short flag on a valid length");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_short_error |-> out_frame_length >= 8'd3 && out_frame_length != 8'h7e)
    else $error("completed frame with an impossible length");

endmodule

bind crc16_framed_packet_checker fpc_checker u_fpc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_channel      (out_channel),
  .out_frame_length (out_frame_length),
  .out_seq_number   (out_seq_number),
  .out_short_error  (out_short_error),
  .out_sync_error   (out_sync_error),
  .out_crc_error    (out_crc_error),
  .out_marker_error (out_marker_error),
  .out_seq_error    (out_seq_error)
);

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two-channel CRC16 framed packet checker.
module testbench;

  localparam int RUN_LIMIT   = 200000;
  localparam int PHASE_WORDS = 283;
  localparam int TAIL_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int PRINT_CAP   = 200;

  // Flag bits in result order: short, sync, crc, marker, sequence.
  localparam logic [4:0] FL_NONE  = 5'b00000;
  localparam logic [4:0] FL_SHORT = 5'b10000;
  localparam logic [4:0] FL_SYNC  = 5'b01000;
  localparam logic [4:0] FL_CRC   = 5'b00100;
  localparam logic [4:0] FL_MARK  = 5'b00010;
  localparam logic [4:0] FL_SEQ   = 5'b00001;

  typedef struct {
    logic             ch;
    logic [7:0]       data;
    logic             typed;
    fpc_pkg::result_t res;
  } dir_row_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_channel   = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_ready    = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       out_channel;
  logic [7:0] out_frame_length;
  logic [3:0] out_seq_number;
  logic       out_short_error;
  logic       out_sync_error;
  logic       out_crc_error;
  logic       out_marker_error;
  logic       out_seq_error;

  crc16_framed_packet_checker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_channel       (in_channel),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_channel      (out_channel),
    .out_frame_length (out_frame_length),
    .out_seq_number   (out_seq_number),
    .out_short_error  (out_short_error),
    .out_sync_error   (out_sync_error),
    .out_crc_error    (out_crc_error),
    .out_marker_error (out_marker_error),
    .out_seq_error    (out_seq_error)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Per-channel frame tracker state.
  fpc_pkg::phase_t fr_phase [fpc_pkg::NUM_CHANNELS];
  logic [7:0]      fr_left  [fpc_pkg::NUM_CHANNELS];
  logic [7:0]      fr_count [fpc_pkg::NUM_CHANNELS];
  logic [7:0]      fr_len   [fpc_pkg::NUM_CHANNELS];
  logic [7:0]      fr_seqb  [fpc_pkg::NUM_CHANNELS];
  logic [15:0]     fr_crc   [fpc_pkg::NUM_CHANNELS];
  logic [15:0]     fr_tail  [fpc_pkg::NUM_CHANNELS];
  logic [3:0]      seq_next [fpc_pkg::NUM_CHANNELS];
  logic            seq_seen [fpc_pkg::NUM_CHANNELS];

  fpc_pkg::result_t frame_reports_due [$];
  logic [7:0]       pend_bytes [fpc_pkg::NUM_CHANNELS][$];
  logic [3:0]       gen_seq [fpc_pkg::NUM_CHANNELS];
  dir_row_t         dir_rows [22];

  int mismatch_count     = 0;
  int words_sent         = 0;
  int cycle_count        = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_req           = 0;
  int hold_left          = 0;

  // Bitwise reflected CRC16-CCITT, polynomial 0x8408.
  function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    return c;
  endfunction

  function automatic void clear_trackers();
    for (int c = 0; c < fpc_pkg::NUM_CHANNELS; c++) begin
      fr_phase[c] = fpc_pkg::PH_IDLE;
      fr_left[c]  = 8'h00;
      fr_count[c] = 8'h00;
      fr_len[c]   = 8'h00;
      fr_seqb[c]  = 8'h00;
      fr_crc[c]   = fpc_pkg::CRC_INIT;
      fr_tail[c]  = 16'h0000;
      seq_next[c] = 4'h0;
      seq_seen[c] = 1'b0;
    end
  endfunction

  // Advances one channel by one byte; returns 1 when the byte ends a frame or is a short length.
  function automatic logic frame_step(input logic ch, input logic [7:0] b,
                                      output fpc_pkg::result_t r);
    logic [3:0] nib;
    r = '0;
    case (fr_phase[ch])
      fpc_pkg::PH_BODY: begin
        // The CRC trails the input by two bytes so the received CRC stays out of it.
        if (fr_count[ch] >= 8'd2) fr_crc[ch] = crc_ccitt_byte(fr_crc[ch], fr_tail[ch][15:8]);
        fr_tail[ch] = {fr_tail[ch][7:0], b};
        if (fr_count[ch] == 8'd1) fr_seqb[ch] = b;
        fr_count[ch] = fr_count[ch] + 8'd1;
        fr_left[ch]  = fr_left[ch] - 8'd1;
        if (fr_left[ch] == 8'd0) fr_phase[ch] = fpc_pkg::PH_SYNC;
        return 1'b0;
      end
      fpc_pkg::PH_SYNC: begin
        nib = fr_seqb[ch][3:0];
        if (!seq_seen[ch]) begin
          seq_next[ch] = nib;
          seq_seen[ch] = 1'b1;
        end
        r.channel      = ch;
        r.frame_length = fr_len[ch];
        r.seq_number   = nib;
        r.sync_error   = (b != fpc_pkg::SYNC_BYTE);
        r.crc_error    = (fr_crc[ch] != fr_tail[ch]);
        r.marker_error = (fr_seqb[ch][7:4] != fpc_pkg::SEQ_MARKER);
        r.seq_error    = (nib != seq_next[ch]);
        seq_next[ch]   = seq_next[ch] + 4'd1;
        fr_phase[ch]   = fpc_pkg::PH_IDLE;
        return 1'b1;
      end
      default: begin
        fr_phase[ch] = fpc_pkg::PH_IDLE;
        if (b == fpc_pkg::SYNC_BYTE) return 1'b0;
        if (b < fpc_pkg::MIN_LENGTH) begin
          r.channel      = ch;
          r.frame_length = b;
          r.short_error  = 1'b1;
          return 1'b1;
        end
        fr_len[ch]   = b;
        fr_left[ch]  = b - 8'd2;
        fr_count[ch] = 8'd1;
        fr_tail[ch]  = {8'h00, b};
        fr_crc[ch]   = fpc_pkg::CRC_INIT;
        fr_seqb[ch]  = 8'h00;
        fr_phase[ch] = fpc_pkg::PH_BODY;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic fpc_pkg::result_t rpt(input logic ch, input logic [7:0] len,
                                           input logic [3:0] seq, input logic [4:0] flags);
    return {ch, len, seq, flags};
  endfunction

  function automatic dir_row_t plain(input logic ch, input logic [7:0] b);
    return '{ch: ch, data: b, typed: 1'b0, res: '0};
  endfunction

  function automatic dir_row_t known(input logic ch, input logic [7:0] b,
                                     input fpc_pkg::result_t r);
    return '{ch: ch, data: b, typed: 1'b1, res: r};
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Offers one word and waits for it to be taken; typed rows override the tracker's result.
  task automatic offer_word(input logic ch, input logic [7:0] b, input logic typed,
                            input fpc_pkg::result_t typed_res);
    fpc_pkg::result_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_channel   <= ch;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (frame_step(ch, b, r)) frame_reports_due.push_back(typed ? typed_res : r);
    words_sent++;
  endtask

  // Queues the bytes of one frame, or of a stray byte, for a channel.
  task automatic queue_frame(input int ch);
    logic [7:0]  fb [$];
    logic [15:0] crc;
    logic [3:0]  hi;
    logic [3:0]  lo;
    int          len;
    int          kind;
    int          flaw;
    int          i;
    kind = $urandom_range(99);
    if (kind < 5) begin
      pend_bytes[ch].push_back(fpc_pkg::SYNC_BYTE);
    end else if (kind < 10) begin
      pend_bytes[ch].push_back(8'($urandom_range(2)));
    end else if (kind < 14) begin
      pend_bytes[ch].push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(39) == 0) len = $urandom_range(1) ? 255 : $urandom_range(200, 254);
      else len = $urandom_range(3, 12);
      flaw = $urandom_range(99);
      hi = fpc_pkg::SEQ_MARKER;
      if (flaw < 6) while (hi == fpc_pkg::SEQ_MARKER) hi = 4'($urandom_range(15));
      lo = (flaw >= 6 && flaw < 12) ? 4'($urandom_range(15)) : gen_seq[ch];
      fb.push_back(8'(len));
      fb.push_back({hi, lo});
      for (i = 2; i < len - 1; i++) fb.push_back(8'($urandom_range(255)));
      // Below length five the CRC slots overlap the sequence byte, and at length three the length byte too.
      if (len >= 5) begin
        crc = fpc_pkg::CRC_INIT;
        for (i = 0; i < len - 3; i++) crc = crc_ccitt_byte(crc, fb[i]);
        fb[len-3] = crc[15:8];
        fb[len-2] = crc[7:0];
        if (flaw >= 12 && flaw < 18) fb[len-2] = fb[len-2] ^ 8'(1 << $urandom_range(7));
      end
      fb.push_back((flaw >= 18 && flaw < 24) ? 8'($urandom_range(255)) : fpc_pkg::SYNC_BYTE);
      gen_seq[ch] = gen_seq[ch] + 4'd1;
      for (i = 0; i < fb.size(); i++) pend_bytes[ch].push_back(fb[i]);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (frame_reports_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int hold);
    int stop_at;
    int ch;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    hold_req           = hold;
    stop_at            = words_sent + PHASE_WORDS;
    while (words_sent < stop_at) begin
      ch = $urandom_range(fpc_pkg::NUM_CHANNELS - 1);
      if (pend_bytes[ch].size() == 0) queue_frame(ch);
      offer_word(1'(ch), pend_bytes[ch].pop_front(), 1'b0, '0);
    end
    settle();
  endtask

  // Result side: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    fpc_pkg::result_t want;
    fpc_pkg::result_t got;
    if (rst_n && out_valid && out_ready) begin
      if (frame_reports_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result ch %0d length %0h", out_channel,
                                out_frame_length));
      end else begin
        want = frame_reports_due.pop_front();
        got  = {out_channel, out_frame_length, out_seq_number, out_short_error,
                out_sync_error, out_crc_error, out_marker_error, out_seq_error};
        if (got !== want) flag_mismatch($sformatf("result got %h expected %h", got, want));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("[crc16_framed_packet_checker] ERROR");
      $finish;
    end
  end

  initial begin
    clear_trackers();
    dir_rows = '{
      known(1'b0, 8'h00, rpt(1'b0, 8'd0, 4'h0, FL_SHORT)),
      known(1'b0, 8'h01, rpt(1'b0, 8'd1, 4'h0, FL_SHORT)),
      known(1'b1, 8'h02, rpt(1'b1, 8'd2, 4'h0, FL_SHORT)),
      plain(1'b0, fpc_pkg::SYNC_BYTE),
      plain(1'b1, fpc_pkg::SYNC_BYTE),
      // Two interleaved length-three frames: the CRC covers nothing.
      plain(1'b0, 8'h03),
      plain(1'b1, 8'h03),
      plain(1'b0, 8'h10),
      plain(1'b1, 8'h1f),
      known(1'b0, fpc_pkg::SYNC_BYTE, rpt(1'b0, 8'd3, 4'h0, FL_CRC)),
      known(1'b1, 8'hff, rpt(1'b1, 8'd3, 4'hf, FL_SYNC | FL_CRC)),
      // Bad marker nibble and a sequence number that skips ahead.
      plain(1'b0, 8'h03),
      plain(1'b0, 8'h25),
      known(1'b0, fpc_pkg::SYNC_BYTE, rpt(1'b0, 8'd3, 4'h5, FL_CRC | FL_MARK | FL_SEQ)),
      plain(1'b1, 8'h04),
      plain(1'b1, 8'h10),
      plain(1'b1, 8'h00),
      plain(1'b1, fpc_pkg::SYNC_BYTE),
      plain(1'b0, 8'h04),
      plain(1'b0, 8'h12),
      plain(1'b0, 8'hff),
      plain(1'b0, fpc_pkg::SYNC_BYTE)
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) offer_word(dir_rows[i].ch, dir_rows[i].data, dir_rows[i].typed,
                                     dir_rows[i].res);
    settle();

    for (int c = 0; c < fpc_pkg::NUM_CHANNELS; c++) gen_seq[c] = seq_next[c];
    // The first phase runs flat out into a long output hold-off, so the input backs up.
    run_phase(0, 0, HOLD_CYCLES);
    run_phase(50, 0, 0);
    run_phase(0, 50, 0);
    run_phase(23, 23, 0);

    if (mismatch_count == 0) begin
      $display("[crc16_framed_packet_checker] OK");
    end else begin
      $display("[crc16_framed_packet_checker] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/fpc_pkg.sv
rtl/fpc_in_stage.sv
rtl/fpc_frame_engine.sv
rtl/fpc_out_stage.sv
rtl/crc16_framed_packet_checker.sv
rtl/fpc_checker.sv
dv/testbench.sv
